@@ rtl/fci_pkg.sv @@
package fci_pkg;

  // steps of the root and divider pipelines, one result bit per step
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 32;
  // accept edge to the edge that takes the result: three input stages, root, divide,
  // seven tail stages
  localparam int PIPE_LAT   = SQRT_STEPS + DIV_STEPS + 10;

  localparam int UNIT_BITS = 30;
  localparam int FRAC_BITS = 28;

  localparam logic [16:0] E_ONE = 17'h10000;

  typedef struct packed {
    logic        [31:0] mass_a;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic        [31:0] mass_b;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
  } fci_in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_a_z;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] new_vel_b_z;
    logic        [31:0] impulse;
    logic               applied;
  } fci_out_t;

endpackage

@@ rtl/frictionless_contact_impulse.sv @@
// frictionless contact impulse with restitution between two bodies
//
// input channel: an item (two masses, two velocities, contact normal from
// b to a, all q16.16) is a transaction at a clock edge with start high and
// busy low. busy stays low, so a new item may enter on every cycle.
// output channel: done is high for exactly one cycle with the updated
// velocities, the impulse magnitude and the applied flag on result. the
// receiver cannot hold results off, and none is needed: the pipe never stalls.
// throughput: one item per cycle. latency is set by the 32-step root pipeline
// for the normal length, followed by the 32-step divider pipeline that forms
// the unit normal; mass shares run beside the root.
// configuration: cfg_we writes cfg_data into the restitution register
// (q1.16, values above 1.0 act as 1.0). write only while no item is in flight.
// reset: rst clears all valid bits and sets restitution to 1.0; items in
// flight are dropped.
module frictionless_contact_impulse import fci_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  fci_in_t     operands,
  input  logic        cfg_we,
  input  logic [16:0] cfg_data,
  output logic        done,
  output fci_out_t    result
);

  localparam int SIDE_LEN = SQRT_STEPS + DIV_STEPS;

  // per-item data that rides beside the root and divider pipelines
  typedef struct packed {
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic [2:0][32:0] dm;
    logic [2:0]       dneg;
    logic [2:0]       nneg;
    logic [2:0][31:0] m;
    logic [31:0]      ma;
    logic [31:0]      mb;
    logic             skip;
  } side_t;

  logic [16:0] restitution;
  logic [16:0] e_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= E_ONE;
    end else if (cfg_we) begin
      restitution <= cfg_data;
    end
  end

  assign e_sat = (restitution > E_ONE) ? E_ONE : restitution;
  assign busy  = 1'b0;

  // stage 1: input capture
  logic    p1_vld;
  fci_in_t p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= start && !busy;
    end
    p1 <= operands;
  end

  // stage 2: magnitudes, squares, velocity differences, mass product and sum
  logic [2:0][31:0] va1, vb1, n1, m1;
  logic [2:0][32:0] dm1;
  logic [2:0]       dneg1, nneg1;

  always_comb begin
    logic [32:0] d;
    va1[0] = p1.vel_a_x;
    va1[1] = p1.vel_a_y;
    va1[2] = p1.vel_a_z;
    vb1[0] = p1.vel_b_x;
    vb1[1] = p1.vel_b_y;
    vb1[2] = p1.vel_b_z;
    n1[0]  = p1.normal_x;
    n1[1]  = p1.normal_y;
    n1[2]  = p1.normal_z;
    for (int i = 0; i < 3; i++) begin
      d        = {va1[i][31], va1[i]} - {vb1[i][31], vb1[i]};
      dneg1[i] = d[32];
      dm1[i]   = d[32] ? (~d + 33'd1) : d;
      nneg1[i] = n1[i][31];
      m1[i]    = n1[i][31] ? (~n1[i] + 32'd1) : n1[i];
    end
  end

  logic             p2_vld;
  side_t            s2;
  logic [2:0][63:0] sqr2;
  logic [63:0]      mprod2;
  logic [32:0]      msum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
    s2.va   <= va1;
    s2.vb   <= vb1;
    s2.dm   <= dm1;
    s2.dneg <= dneg1;
    s2.nneg <= nneg1;
    s2.m    <= m1;
    s2.ma   <= p1.mass_a;
    s2.mb   <= p1.mass_b;
    s2.skip <= (p1.mass_a == 32'd0) && (p1.mass_b == 32'd0);
    for (int i = 0; i < 3; i++) begin
      sqr2[i] <= {32'd0, m1[i]} * {32'd0, m1[i]};
    end
    mprod2 <= {32'd0, p1.mass_a} * {32'd0, p1.mass_b};
    msum2  <= {1'b0, p1.mass_a} + {1'b0, p1.mass_b};
  end

  // stage 3: squared length of the normal
  logic        p3_vld;
  side_t       s3;
  side_t       s2_len;
  logic [63:0] l2_3;
  logic [63:0] mprod3;
  logic [32:0] msum3;
  logic [63:0] l2_sum;

  assign l2_sum = sqr2[0] + sqr2[1] + sqr2[2];

  // zero normal joins the pass-through cases
  always_comb begin
    s2_len      = s2;
    s2_len.skip = s2.skip || (l2_sum == 64'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else begin
      p3_vld <= p2_vld;
    end
    s3      <= s2_len;
    l2_3    <= l2_sum;
    mprod3  <= mprod2;
    msum3   <= msum2;
  end

  // normal length, and mass shares and reduced mass in parallel
  logic [31:0] len;
  logic [31:0] qa_raw, qb_raw, qm_raw;

  fci_isqrt u_isqrt (
    .clk      (clk),
    .radicand (l2_3),
    .root     (len)
  );

  fci_div u_div_fa (
    .clk      (clk),
    .dividend ({4'd0, s3.mb, 28'd0}),
    .divisor  (msum3),
    .quotient (qa_raw)
  );

  fci_div u_div_fb (
    .clk      (clk),
    .dividend ({4'd0, s3.ma, 28'd0}),
    .divisor  (msum3),
    .quotient (qb_raw)
  );

  fci_div u_div_mu (
    .clk      (clk),
    .dividend (mprod3),
    .divisor  (msum3),
    .quotient (qm_raw)
  );

  // side data delay line and mass quotient delay lines
  side_t       sd    [1:SIDE_LEN];
  logic        vl    [1:SIDE_LEN];
  logic [31:0] qa_d  [1:DIV_STEPS];
  logic [31:0] qb_d  [1:DIV_STEPS];
  logic [31:0] qm_d  [1:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= SIDE_LEN; k++) begin
        vl[k] <= 1'b0;
      end
    end else begin
      vl[1] <= p3_vld;
      for (int k = 2; k <= SIDE_LEN; k++) begin
        vl[k] <= vl[k-1];
      end
    end
    sd[1] <= s3;
    for (int k = 2; k <= SIDE_LEN; k++) begin
      sd[k] <= sd[k-1];
    end
    qa_d[1] <= qa_raw;
    qb_d[1] <= qb_raw;
    qm_d[1] <= qm_raw;
    for (int k = 2; k <= DIV_STEPS; k++) begin
      qa_d[k] <= qa_d[k-1];
      qb_d[k] <= qb_d[k-1];
      qm_d[k] <= qm_d[k-1];
    end
  end

  // unit normal, q1.30, one divider per axis
  logic [2:0][31:0] uq;

  for (genvar g = 0; g < 3; g++) begin : g_unit
    fci_div u_div_u (
      .clk      (clk),
      .dividend ({2'd0, sd[SQRT_STEPS].m[g], 30'd0}),
      .divisor  ({1'b0, len}),
      .quotient (uq[g])
    );
  end

  side_t s_end;
  assign s_end = sd[SIDE_LEN];

  // stage 4: relative velocity terms along the normal, share selection
  logic             p4_vld;
  side_t            s4;
  logic [2:0][63:0] t4;
  logic [2:0]       tn4;
  logic [2:0][30:0] u4;
  logic [28:0]      fa4, fb4;
  logic [31:0]      mu4;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_vld <= 1'b0;
    end else begin
      p4_vld <= vl[SIDE_LEN];
    end
    s4 <= s_end;
    for (int i = 0; i < 3; i++) begin
      t4[i]  <= {31'd0, s_end.dm[i]} * {33'd0, uq[i][30:0]};
      tn4[i] <= s_end.dneg[i] != s_end.nneg[i];
      u4[i]  <= uq[i][30:0];
    end
    // immovable body takes no share, the other takes all of it
    if (s_end.ma == 32'd0) begin
      fa4 <= '0;
    end else if (s_end.mb == 32'd0) begin
      fa4 <= 29'h1000_0000;
    end else begin
      fa4 <= qa_d[DIV_STEPS][28:0];
    end
    if (s_end.mb == 32'd0) begin
      fb4 <= '0;
    end else if (s_end.ma == 32'd0) begin
      fb4 <= 29'h1000_0000;
    end else begin
      fb4 <= qb_d[DIV_STEPS][28:0];
    end
    if (s_end.ma == 32'd0) begin
      mu4 <= s_end.mb;
    end else if (s_end.mb == 32'd0) begin
      mu4 <= s_end.ma;
    end else begin
      mu4 <= qm_d[DIV_STEPS];
    end
  end

  // stage 5: positive and negative accumulators
  logic             p5_vld;
  side_t            s5;
  logic [63:0]      pos5, neg5;
  logic [2:0][30:0] u5;
  logic [28:0]      fa5, fb5;
  logic [31:0]      mu5;
  logic [63:0]      pos_sum, neg_sum;

  always_comb begin
    pos_sum = '0;
    neg_sum = '0;
    for (int i = 0; i < 3; i++) begin
      if (tn4[i]) begin
        neg_sum = neg_sum + t4[i];
      end else begin
        pos_sum = pos_sum + t4[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_vld <= 1'b0;
    end else begin
      p5_vld <= p4_vld;
    end
    s5   <= s4;
    pos5 <= pos_sum;
    neg5 <= neg_sum;
    u5   <= u4;
    fa5  <= fa4;
    fb5  <= fb4;
    mu5  <= mu4;
  end

  // stage 6: approach test and closing speed
  logic             p6_vld;
  side_t            s6;
  logic             go6;
  logic [33:0]      sq6;
  logic [2:0][30:0] u6;
  logic [28:0]      fa6, fb6;
  logic [31:0]      mu6;
  logic [63:0]      close;

  assign close = neg5 - pos5;

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_vld <= 1'b0;
    end else begin
      p6_vld <= p5_vld;
    end
    s6  <= s5;
    go6 <= !s5.skip && (neg5 > pos5);
    sq6 <= close[63:UNIT_BITS];
    u6  <= u5;
    fa6 <= fa5;
    fb6 <= fb5;
    mu6 <= mu5;
  end

  // stage 7: total normal velocity change g = sq * (1 + e)
  logic             p7_vld;
  side_t            s7;
  logic             go7;
  logic [35:0]      g7;
  logic [2:0][30:0] u7;
  logic [28:0]      fa7, fb7;
  logic [31:0]      mu7;
  logic [17:0]      one_e;
  logic [51:0]      gprod;

  assign one_e = {1'b0, e_sat} + 18'h10000;
  assign gprod = {18'd0, sq6} * {34'd0, one_e};

  always_ff @(posedge clk) begin
    if (rst) begin
      p7_vld <= 1'b0;
    end else begin
      p7_vld <= p6_vld;
    end
    s7  <= s6;
    go7 <= go6;
    g7  <= gprod[51:16];
    u7  <= u6;
    fa7 <= fa6;
    fb7 <= fb6;
    mu7 <= mu6;
  end

  // stage 8: per-body changes and impulse magnitude
  logic             p8_vld;
  side_t            s8;
  logic             go8;
  logic [35:0]      da8, db8;
  logic [31:0]      imp8;
  logic [2:0][30:0] u8;
  logic [64:0]      daprod, dbprod;
  logic [67:0]      iprod;

  assign daprod = {29'd0, g7} * {36'd0, fa7};
  assign dbprod = {29'd0, g7} * {36'd0, fb7};
  assign iprod  = {32'd0, g7} * {36'd0, mu7};

  always_ff @(posedge clk) begin
    if (rst) begin
      p8_vld <= 1'b0;
    end else begin
      p8_vld <= p7_vld;
    end
    s8  <= s7;
    go8 <= go7;
    da8 <= daprod[63:FRAC_BITS];
    db8 <= dbprod[63:FRAC_BITS];
    // impulse saturates at all ones
    imp8 <= (|iprod[67:48]) ? 32'hFFFF_FFFF : iprod[47:16];
    u8  <= u7;
  end

  // stage 9: component changes, clamped to 2^34
  logic             p9_vld;
  side_t            s9;
  logic             go9;
  logic [31:0]      imp9;
  logic [2:0][34:0] ca9, cb9;
  logic [2:0][34:0] ca_c, cb_c;

  always_comb begin
    logic [66:0] pa, pb;
    for (int i = 0; i < 3; i++) begin
      pa = {31'd0, da8} * {36'd0, u8[i]};
      pb = {31'd0, db8} * {36'd0, u8[i]};
      ca_c[i] = (pa[66:UNIT_BITS] > 37'h4_0000_0000) ? 35'h4_0000_0000
                                                       : pa[64:UNIT_BITS];
      cb_c[i] = (pb[66:UNIT_BITS] > 37'h4_0000_0000) ? 35'h4_0000_0000
                                                       : pb[64:UNIT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p9_vld <= 1'b0;
    end else begin
      p9_vld <= p8_vld;
    end
    s9   <= s8;
    go9  <= go8;
    imp9 <= imp8;
    ca9  <= ca_c;
    cb9  <= cb_c;
  end

  // stage 10: apply changes with saturation, result register
  logic [2:0][31:0] ra, rb;

  function automatic logic [31:0] sat_add(logic [31:0] v, logic [34:0] c, logic neg);
    logic [36:0] sum;
    logic [36:0] delta;
    delta = neg ? (~{2'b00, c} + 37'd1) : {2'b00, c};
    sum   = {{5{v[31]}}, v} + delta;
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      return sum[31:0];
    end
    return sum[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // a moves along the normal, b against it
      ra[i] = go9 ? sat_add(s9.va[i], ca9[i], s9.nneg[i]) : s9.va[i];
      rb[i] = go9 ? sat_add(s9.vb[i], cb9[i], !s9.nneg[i]) : s9.vb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p9_vld;
    end
    result.new_vel_a_x <= ra[0];
    result.new_vel_a_y <= ra[1];
    result.new_vel_a_z <= ra[2];
    result.new_vel_b_x <= rb[0];
    result.new_vel_b_y <= rb[1];
    result.new_vel_b_z <= rb[2];
    result.impulse     <= go9 ? imp9 : 32'd0;
    result.applied     <= go9;
  end

endmodule

@@ rtl/fci_isqrt.sv @@
module fci_isqrt import fci_pkg::*; (
  input  logic        clk,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  typedef struct packed {
    logic [63:0] x;
    logic [63:0] r;
  } sq_st_t;

  sq_st_t st [1:SQRT_STEPS];
  sq_st_t head;

  // one digit of the bitwise root, bit weight 4^k
  function automatic sq_st_t sq_step(sq_st_t s, int k);
    logic [63:0] bit_w;
    logic [63:0] trial;
    sq_st_t      n;
    bit_w = 64'd1 << (2 * k);
    trial = s.r + bit_w;
    if (s.x >= trial) begin
      n.x = s.x - trial;
      n.r = (s.r >> 1) + bit_w;
    end else begin
      n.x = s.x;
      n.r = s.r >> 1;
    end
    return n;
  endfunction

  assign head.x = radicand;
  assign head.r = '0;

  always_ff @(posedge clk) begin
    st[1] <= sq_step(head, SQRT_STEPS - 1);
    for (int j = 2; j <= SQRT_STEPS; j++) begin
      st[j] <= sq_step(st[j-1], SQRT_STEPS - j);
    end
  end

  assign root = st[SQRT_STEPS].r[31:0];

endmodule

@@ rtl/fci_div.sv @@
module fci_div import fci_pkg::*; (
  input  logic        clk,
  input  logic [63:0] dividend,
  input  logic [32:0] divisor,
  output logic [31:0] quotient
);

  // restoring division, quotient known to fit in 32 bits
  typedef struct packed {
    logic [63:0] rem;
    logic [32:0] d;
    logic [31:0] q;
  } dv_st_t;

  dv_st_t st [1:DIV_STEPS];
  dv_st_t head;

  function automatic dv_st_t dv_step(dv_st_t s, int k);
    logic [64:0] sd;
    dv_st_t      n;
    sd = 65'(s.d) << k;
    n  = s;
    if ({1'b0, s.rem} >= sd) begin
      n.rem = s.rem - sd[63:0];
      n.q   = s.q | (32'd1 << k);
    end
    return n;
  endfunction

  assign head.rem = dividend;
  assign head.d   = divisor;
  assign head.q   = '0;

  always_ff @(posedge clk) begin
    st[1] <= dv_step(head, DIV_STEPS - 1);
    for (int j = 2; j <= DIV_STEPS; j++) begin
      st[j] <= dv_step(st[j-1], DIV_STEPS - j);
    end
  end

  assign quotient = st[DIV_STEPS].q;

endmodule

@@ rtl/fci_checker.sv @@
module fci_checker import fci_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input fci_in_t  operands,
  input logic     done,
  input fci_out_t result
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result strobe without matching transaction");

  a_pass_through: assert property (@(posedge clk) disable iff (rst)
    done && !result.applied |->
      result.impulse == 32'd0 &&
      result.new_vel_a_x == $past(operands.vel_a_x, PIPE_LAT) &&
      result.new_vel_b_z == $past(operands.vel_b_z, PIPE_LAT))
    else $error("pass-through changed the velocities");

  a_applied_needs_normal: assert property (@(posedge clk) disable iff (rst)
    done && result.applied |->
      $past(operands.normal_x != 32'd0 || operands.normal_y != 32'd0 ||
            operands.normal_z != 32'd0, PIPE_LAT) &&
      $past(operands.mass_a != 32'd0 || operands.mass_b != 32'd0, PIPE_LAT))
    else $error("impulse applied on zero normal or two immovable bodies");

endmodule

bind frictionless_contact_impulse fci_checker u_fci_checker (.*);
